// File: sv/est_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds timekeeper package
// Request kinds, register indexes, calendar constants, and the types and
// helper functions shared by the top level and the conversion engine.
// ----------------------------------------------------------------------------
package est_pkg;

    // Request kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SET  = 2'd1;
    localparam logic [1:0] KIND_GET  = 2'd2;

    // Configuration register indexes
    localparam int REG_DRIFT = 0;
    localparam int REG_TPS   = 1;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [15:0] DRIFT_RESET = 16'd10;
    localparam logic [15:0] TPS_RESET   = 16'd1000;

    // Time constants in seconds
    localparam logic [31:0] DAY_SECS  = 32'd86400;
    localparam logic [31:0] HOUR_SECS = 32'd3600;
    localparam logic [31:0] MIN_SECS  = 32'd60;
    localparam logic [31:0] YEAR_SECS = 32'h01E1_3380;

    // Valid window of the counter for calendar readout (exclusive bounds)
    localparam logic [31:0] WIN_LOW  = 32'h0B47_3500;
    localparam logic [31:0] WIN_HIGH = 32'hBC19_1380;

    // Supported set years, counted from 2000
    localparam logic [6:0] FIRST_YEAR = 7'd10;
    localparam logic [6:0] LAST_YEAR  = 7'd70;
    localparam logic [6:0] CENTURY_YEAR = 7'd100;

    // Month bounds
    localparam logic [3:0] MONTH_FEB  = 4'd2;
    localparam logic [3:0] MONTH_DEC  = 4'd12;
    localparam logic [3:0] MONTH_PAST = 4'd13;

    // Request into the conversion engine
    typedef struct packed {
        logic       is_set;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       force_req;
    } est_req_t;

    // Result out of the conversion engine
    typedef struct packed {
        logic        is_set;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] epoch;
        logic        cal_valid;
        logic        applied;
    } est_res_t;

    // Control from the top level into the engine
    typedef struct packed {
        logic start;
        logic take;
    } est_ctl_t;

    // Status from the engine to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } est_sts_t;

    // Gregorian leap rule for years 2000..2127 given as offset from 2000
    function automatic logic is_leap(logic [6:0] yc);
        return (yc[1:0] == 2'b00) && (yc != CENTURY_YEAR);
    endfunction

    // Seconds in a month of a common year; zero for codes that are no month
    function automatic logic [31:0] month_secs(logic [3:0] m);
        logic [31:0] secs;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: secs = 32'd2678400;
            4'd4, 4'd6, 4'd9, 4'd11:                    secs = 32'd2592000;
            4'd2:                                       secs = 32'd2419200;
            default:                                    secs = 32'd0;
        endcase
        return secs;
    endfunction

endpackage

// File: sv/epoch_seconds_timekeeper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds timekeeper
// Seconds counter from 2010-01-01 with sub-second tick divider, calendar set
// with drift check, and calendar readout of the counter.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall; kind selects tick, set or get.
//   A tick request gives no result; kind 3 is dropped the same way. Set
//   and get requests each give one result on out_valid/out_stall, held in
//   an output register.
//   A set request for a year outside 2010..2070 goes straight to the drift
//   check; otherwise it runs the year loop (one shared adder pass per year
//   since 2010), one pass per month, then day, hour, minute and second.
//   A get request outside the window skips the calendar walk; otherwise it
//   takes one shared subtractor pass per year, month, day, hour and minute.
//   in_stall is high from the accepting edge until the result moves into
//   the output register; a new request is taken from that cycle on, and
//   ticks are still taken while an earlier result waits there.
//   If the receiver stalls, a finished conversion waits (input stalled) until
//   the output register frees up, then hands over its result.
//   Reset clears counters and the set flag and loads drift_threshold = 10,
//   ticks_per_second = 1000. Configuration writes (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) are always ready and belong in idle periods.
// ----------------------------------------------------------------------------
module epoch_seconds_timekeeper_top #(
    parameter int CFG_IDX_W = est_pkg::CFG_IDX_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           kind,
    input  logic [6:0]           year,
    input  logic [3:0]           month,
    input  logic [4:0]           day,
    input  logic [4:0]           hour,
    input  logic [5:0]           minute,
    input  logic [5:0]           second,
    input  logic                 force_req,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [6:0]           out_year,
    output logic [3:0]           out_month,
    output logic [4:0]           out_day,
    output logic [4:0]           out_hour,
    output logic [5:0]           out_minute,
    output logic [5:0]           out_second,
    output logic [31:0]          epoch_seconds,
    output logic [31:0]          uptime_ticks,
    output logic                 calendar_valid,
    output logic                 applied,
    output logic                 time_checked,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [31:0] seconds_reg, seconds_next;
    logic [15:0] subsec_reg, subsec_next;
    logic [31:0] uptime_reg, uptime_next;
    logic        checked_reg, checked_next;
    logic [15:0] drift_reg, drift_next;
    logic [15:0] tps_reg, tps_next;
    logic        out_valid_reg, out_valid_next;

    est_pkg::est_res_t out_res_reg;
    logic [31:0]       out_uptime_reg;
    logic              out_checked_reg;

    est_pkg::est_ctl_t ctl;
    est_pkg::est_sts_t sts;
    est_pkg::est_req_t req;
    est_pkg::est_res_t res;

    logic        in_accept;
    logic        tick;
    logic        cfg_write;
    logic [16:0] subsec_inc;

    // Request decode
    assign in_stall  = sts.busy;
    assign in_accept = in_valid && !in_stall;
    assign tick      = in_accept && (kind == est_pkg::KIND_TICK);
    assign ctl.start = in_accept && (kind == est_pkg::KIND_SET || kind == est_pkg::KIND_GET);
    assign ctl.take  = sts.done && (!out_valid_reg || !out_stall);

    assign req.is_set    = (kind == est_pkg::KIND_SET);
    assign req.year      = year;
    assign req.month     = month;
    assign req.day       = day;
    assign req.hour      = hour;
    assign req.minute    = minute;
    assign req.second    = second;
    assign req.force_req = force_req;

    est_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req       (req),
        .count     (seconds_reg),
        .threshold (drift_reg),
        .sts       (sts),
        .res       (res)
    );

    // Config writes
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        drift_next = drift_reg;
        tps_next   = tps_reg;
        if (cfg_write && cfg_index == CFG_IDX_W'(est_pkg::REG_DRIFT))
            drift_next = cfg_data;
        if (cfg_write && cfg_index == CFG_IDX_W'(est_pkg::REG_TPS))
            tps_next = cfg_data;
    end

    // Advance the counters on ticks, load on an applied set
    assign subsec_inc = {1'b0, subsec_reg} + 17'd1;

    always_comb
    begin
        seconds_next = seconds_reg;
        subsec_next  = subsec_reg;
        uptime_next  = uptime_reg;
        checked_next = checked_reg;
        if (tick)
        begin
            uptime_next = uptime_reg + 32'd1;
            if (subsec_inc >= {1'b0, tps_reg})
            begin
                subsec_next  = 16'd0;
                seconds_next = seconds_reg + 32'd1;
            end
            else
            begin
                subsec_next = subsec_inc[15:0];
            end
        end
        if (ctl.take && res.is_set)
        begin
            checked_next = 1'b1;
            if (res.applied)
                seconds_next = res.epoch;
        end
    end

    // Output register: load on take, drop when the receiver takes it
    always_comb
    begin
        if (ctl.take)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seconds_reg   <= 32'd0;
            subsec_reg    <= 16'd0;
            uptime_reg    <= 32'd0;
            checked_reg   <= 1'b0;
            drift_reg     <= est_pkg::DRIFT_RESET;
            tps_reg       <= est_pkg::TPS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seconds_reg   <= seconds_next;
            subsec_reg    <= subsec_next;
            uptime_reg    <= uptime_next;
            checked_reg   <= checked_next;
            drift_reg     <= drift_next;
            tps_reg       <= tps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            out_res_reg     <= res;
            out_uptime_reg  <= uptime_reg;
            out_checked_reg <= checked_reg | res.is_set;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_year       = out_res_reg.year;
    assign out_month      = out_res_reg.month;
    assign out_day        = out_res_reg.day;
    assign out_hour       = out_res_reg.hour;
    assign out_minute     = out_res_reg.minute;
    assign out_second     = out_res_reg.second;
    assign epoch_seconds  = out_res_reg.epoch;
    assign uptime_ticks   = out_uptime_reg;
    assign calendar_valid = out_res_reg.cal_valid;
    assign applied        = out_res_reg.applied;
    assign time_checked   = out_checked_reg;

endmodule

// File: sv/est_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds conversion engine
// Sequencer around one shared 32-bit add/subtract unit. Converts a calendar
// date to seconds and checks drift for set requests; walks the counter down
// through years, months, days, hours and minutes for get requests.
// ----------------------------------------------------------------------------
module est_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  est_pkg::est_ctl_t ctl,
    input  est_pkg::est_req_t req,
    input  logic [31:0]      count,
    input  logic [15:0]      threshold,
    output est_pkg::est_sts_t sts,
    output est_pkg::est_res_t res
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SYEAR = 5'd1;
    localparam logic [4:0] ST_SMON  = 5'd2;
    localparam logic [4:0] ST_SLEAP = 5'd3;
    localparam logic [4:0] ST_SDAY  = 5'd4;
    localparam logic [4:0] ST_SHOUR = 5'd5;
    localparam logic [4:0] ST_SMIN  = 5'd6;
    localparam logic [4:0] ST_SSEC  = 5'd7;
    localparam logic [4:0] ST_SDIFF = 5'd8;
    localparam logic [4:0] ST_SABS  = 5'd9;
    localparam logic [4:0] ST_SCMP  = 5'd10;
    localparam logic [4:0] ST_GYEAR = 5'd11;
    localparam logic [4:0] ST_GMON  = 5'd12;
    localparam logic [4:0] ST_GDAY  = 5'd13;
    localparam logic [4:0] ST_GHOUR = 5'd14;
    localparam logic [4:0] ST_GMIN  = 5'd15;
    localparam logic [4:0] ST_DONE  = 5'd16;

    logic [4:0]        state_reg, state_next;
    est_pkg::est_req_t req_reg, req_next;
    est_pkg::est_res_t res_reg, res_next;
    logic [31:0]       acc_reg, acc_next;
    logic [31:0]       diff_reg, diff_next;
    logic [6:0]        yc_reg, yc_next;
    logic [3:0]        mc_reg, mc_next;
    logic [5:0]        cnt_reg, cnt_next;

    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic        alu_sub;
    logic [32:0] alu_sum;
    logic        alu_borrow;
    logic [3:0]  mon_top;
    logic [31:0] leap_day;

    // Shared add/subtract unit
    assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                        + {32'd0, alu_sub};
    assign alu_borrow = alu_sub & ~alu_sum[32];

    // Months counted in full for a set request
    assign mon_top  = (req_reg.month > est_pkg::MONTH_DEC) ? est_pkg::MONTH_PAST
                                                           : req_reg.month;
    assign leap_day = est_pkg::is_leap(yc_reg) ? est_pkg::DAY_SECS : 32'd0;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        acc_next   = acc_reg;
        diff_next  = diff_reg;
        yc_next    = yc_reg;
        mc_next    = mc_reg;
        cnt_next   = cnt_reg;
        alu_a      = acc_reg;
        alu_b      = 32'd0;
        alu_sub    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    req_next        = req;
                    res_next        = '0;
                    res_next.is_set = req.is_set;
                    yc_next         = est_pkg::FIRST_YEAR;
                    mc_next         = 4'd1;
                    cnt_next        = 6'd0;
                    if (req.is_set)
                    begin
                        // Start one day below zero: day of month counts from one
                        acc_next = 32'd0 - est_pkg::DAY_SECS;
                        if (req.year < est_pkg::FIRST_YEAR || req.year > est_pkg::LAST_YEAR)
                        begin
                            acc_next   = 32'd0;
                            state_next = ST_SDIFF;
                        end
                        else
                        begin
                            state_next = ST_SYEAR;
                        end
                    end
                    else
                    begin
                        acc_next       = count;
                        res_next.epoch = count;
                        if (count > est_pkg::WIN_LOW && count < est_pkg::WIN_HIGH)
                            state_next = ST_GYEAR;
                        else
                            state_next = ST_DONE;
                    end
                end
            end

            // Add whole years up to the requested one
            ST_SYEAR:
            begin
                alu_b = est_pkg::YEAR_SECS + leap_day;
                if (yc_reg == req_reg.year)
                begin
                    state_next = ST_SMON;
                end
                else
                begin
                    acc_next = alu_sum[31:0];
                    yc_next  = yc_reg + 7'd1;
                end
            end

            // Add whole months before the requested one
            ST_SMON:
            begin
                alu_b = est_pkg::month_secs(mc_reg);
                if (mc_reg >= mon_top)
                begin
                    state_next = ST_SLEAP;
                end
                else
                begin
                    acc_next = alu_sum[31:0];
                    mc_next  = mc_reg + 4'd1;
                end
            end

            ST_SLEAP:
            begin
                alu_b = (est_pkg::is_leap(req_reg.year) && req_reg.month > est_pkg::MONTH_FEB)
                        ? est_pkg::DAY_SECS : 32'd0;
                acc_next   = alu_sum[31:0];
                state_next = ST_SDAY;
            end

            ST_SDAY:
            begin
                alu_b      = 32'(req_reg.day) * est_pkg::DAY_SECS;
                acc_next   = alu_sum[31:0];
                state_next = ST_SHOUR;
            end

            ST_SHOUR:
            begin
                alu_b      = 32'(req_reg.hour) * est_pkg::HOUR_SECS;
                acc_next   = alu_sum[31:0];
                state_next = ST_SMIN;
            end

            ST_SMIN:
            begin
                alu_b      = 32'(req_reg.minute) * est_pkg::MIN_SECS;
                acc_next   = alu_sum[31:0];
                state_next = ST_SSEC;
            end

            ST_SSEC:
            begin
                alu_b      = 32'(req_reg.second);
                acc_next   = alu_sum[31:0];
                state_next = ST_SDIFF;
            end

            // Distance between counter and converted value
            ST_SDIFF:
            begin
                alu_a   = count;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
                if (alu_borrow)
                begin
                    state_next = ST_SABS;
                end
                else
                begin
                    diff_next  = alu_sum[31:0];
                    state_next = ST_SCMP;
                end
            end

            ST_SABS:
            begin
                alu_b      = count;
                alu_sub    = 1'b1;
                diff_next  = alu_sum[31:0];
                state_next = ST_SCMP;
            end

            ST_SCMP:
            begin
                res_next.epoch   = acc_reg;
                res_next.applied = req_reg.force_req || (diff_reg > {16'd0, threshold});
                state_next       = ST_DONE;
            end

            // Strip whole years off the counter
            ST_GYEAR:
            begin
                alu_b   = est_pkg::YEAR_SECS + leap_day;
                alu_sub = 1'b1;
                if (alu_borrow)
                begin
                    state_next = ST_GMON;
                end
                else
                begin
                    acc_next = alu_sum[31:0];
                    yc_next  = yc_reg + 7'd1;
                end
            end

            // Strip whole months, stop at December
            ST_GMON:
            begin
                alu_b   = est_pkg::month_secs(mc_reg)
                          + ((mc_reg == est_pkg::MONTH_FEB) ? leap_day : 32'd0);
                alu_sub = 1'b1;
                if (alu_borrow || mc_reg >= est_pkg::MONTH_DEC)
                begin
                    cnt_next   = 6'd0;
                    state_next = ST_GDAY;
                end
                else
                begin
                    acc_next = alu_sum[31:0];
                    mc_next  = mc_reg + 4'd1;
                end
            end

            ST_GDAY:
            begin
                alu_b   = est_pkg::DAY_SECS;
                alu_sub = 1'b1;
                if (alu_borrow)
                begin
                    res_next.day = cnt_reg[4:0] + 5'd1;
                    cnt_next     = 6'd0;
                    state_next   = ST_GHOUR;
                end
                else
                begin
                    acc_next = alu_sum[31:0];
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            ST_GHOUR:
            begin
                alu_b   = est_pkg::HOUR_SECS;
                alu_sub = 1'b1;
                if (alu_borrow)
                begin
                    res_next.hour = cnt_reg[4:0];
                    cnt_next      = 6'd0;
                    state_next    = ST_GMIN;
                end
                else
                begin
                    acc_next = alu_sum[31:0];
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            ST_GMIN:
            begin
                alu_b   = est_pkg::MIN_SECS;
                alu_sub = 1'b1;
                if (alu_borrow)
                begin
                    res_next.minute    = cnt_reg;
                    res_next.second    = acc_reg[5:0];
                    res_next.year      = yc_reg;
                    res_next.month     = mc_reg;
                    res_next.cal_valid = 1'b1;
                    state_next         = ST_DONE;
                end
                else
                begin
                    acc_next = alu_sum[31:0];
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            // Hold the result until the top level takes it
            ST_DONE:
            begin
                if (ctl.take)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        res_reg  <= res_next;
        acc_reg  <= acc_next;
        diff_reg <= diff_next;
        yc_reg   <= yc_next;
        mc_reg   <= mc_next;
        cnt_reg  <= cnt_next;
    end

    assign sts.busy = (state_reg != ST_IDLE);
    assign sts.done = (state_reg == ST_DONE);
    assign res      = res_reg;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds timekeeper testbench
// Drives tick, set and get requests with random gaps and output stalls,
// predicts each set and get result from its own model of the counters and the
// calendar conversion, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CFG_IDX_W = est_pkg::CFG_IDX_W;
    localparam int unsigned CAL_BASE_YEAR = 2000;
    localparam int unsigned FIRST_CAL_YEAR = CAL_BASE_YEAR + est_pkg::FIRST_YEAR;
    localparam int unsigned LAST_CAL_YEAR = CAL_BASE_YEAR + est_pkg::LAST_YEAR;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLDOFF_CYCLES = 800;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASES = 8;

    // One request on the input channel
    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       force_req;
    } clock_req_t;

    // One result on the output channel
    typedef struct packed {
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] epoch;
        logic [31:0] uptime;
        logic        cal_valid;
        logic        applied;
        logic        checked;
    } readout_t;

    // ------------------------------------------------------------------------
    // Timekeeper scoreboard: mirrors the counters and queues expected readouts
    // ------------------------------------------------------------------------
    class timekeeper_scoreboard;
        int unsigned secs;
        int unsigned subsec;
        int unsigned uptime;
        bit          have_set;
        int unsigned drift_limit;
        int unsigned tick_period;
        int unsigned month_days[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        readout_t    pending_readouts[$];
        int          mismatches;

        function new();
            secs = 0;
            subsec = 0;
            uptime = 0;
            have_set = 0;
            drift_limit = est_pkg::DRIFT_RESET;
            tick_period = est_pkg::TPS_RESET;
            mismatches = 0;
        endfunction

        function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function void write_register(int idx, logic [15:0] value);
            if (idx == est_pkg::REG_DRIFT)
                drift_limit = value;
            else if (idx == est_pkg::REG_TPS)
                tick_period = value;
        endfunction

        // Calendar date to seconds since 2010, wrapping at 32 bits
        function int unsigned seconds_of_date(clock_req_t q);
            int unsigned y;
            int unsigned days;
            int unsigned top;
            int unsigned i;
            y = CAL_BASE_YEAR + q.year;
            if (y < FIRST_CAL_YEAR || y > LAST_CAL_YEAR)
                return 0;
            days = 0;
            for (i = FIRST_CAL_YEAR; i < y; i++)
                days += 365 + leap_year(i);
            top = (q.month > est_pkg::MONTH_DEC) ? est_pkg::MONTH_PAST : q.month;
            for (i = 1; i < top; i++)
                days += month_days[i];
            days += q.day;
            if (leap_year(y) && q.month > est_pkg::MONTH_FEB)
                days++;
            return (days - 1) * est_pkg::DAY_SECS + q.hour * est_pkg::HOUR_SECS
                + q.minute * est_pkg::MIN_SECS + q.second;
        endfunction

        // Seconds count back to calendar fields; zeros outside the window
        function readout_t calendar_of_seconds(int unsigned count);
            readout_t r;
            int unsigned c;
            int unsigned y;
            int unsigned m;
            int unsigned len;
            r = '0;
            r.epoch = count;
            c = count;
            y = FIRST_CAL_YEAR;
            m = 1;
            if (c > est_pkg::WIN_LOW && c < est_pkg::WIN_HIGH)
            begin
                while (1)
                begin
                    len = est_pkg::YEAR_SECS + leap_year(y) * est_pkg::DAY_SECS;
                    if (c < len)
                        break;
                    c -= len;
                    y++;
                end
                while (1)
                begin
                    len = month_days[m] * est_pkg::DAY_SECS;
                    if (m == est_pkg::MONTH_FEB && leap_year(y))
                        len += est_pkg::DAY_SECS;
                    if (c < len || m >= est_pkg::MONTH_DEC)
                        break;
                    c -= len;
                    m++;
                end
                r.year = 7'(y - CAL_BASE_YEAR);
                r.month = 4'(m);
                r.day = 5'(c / est_pkg::DAY_SECS + 1);
                c = c % est_pkg::DAY_SECS;
                r.hour = 5'(c / est_pkg::HOUR_SECS);
                c = c % est_pkg::HOUR_SECS;
                r.minute = 6'(c / est_pkg::MIN_SECS);
                r.second = 6'(c % est_pkg::MIN_SECS);
                r.cal_valid = 1'b1;
            end
            return r;
        endfunction

        // Advance the model by one accepted request
        function void note_request(clock_req_t q);
            readout_t r;
            int unsigned next_sub;
            int unsigned target;
            int unsigned diff;
            bit load;
            if (q.kind == est_pkg::KIND_TICK)
            begin
                next_sub = subsec + 1;
                uptime++;
                if (next_sub >= tick_period)
                begin
                    subsec = 0;
                    secs++;
                end
                else
                begin
                    subsec = next_sub & 16'hFFFF;
                end
            end
            else if (q.kind == est_pkg::KIND_SET)
            begin
                target = seconds_of_date(q);
                diff = (secs > target) ? secs - target : target - secs;
                load = q.force_req || diff > drift_limit;
                have_set = 1'b1;
                if (load)
                    secs = target;
                r = '0;
                r.epoch = target;
                r.applied = load;
                r.uptime = uptime;
                r.checked = have_set;
                pending_readouts.push_back(r);
            end
            else if (q.kind == est_pkg::KIND_GET)
            begin
                r = calendar_of_seconds(secs);
                r.uptime = uptime;
                r.checked = have_set;
                pending_readouts.push_back(r);
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_readout(readout_t got);
            readout_t want;
            if (pending_readouts.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result expected none actual epoch_seconds %0h",
                         $time, got.epoch);
                return;
            end
            want = pending_readouts.pop_front();
            check_field("out_year", want.year, got.year);
            check_field("out_month", want.month, got.month);
            check_field("out_day", want.day, got.day);
            check_field("out_hour", want.hour, got.hour);
            check_field("out_minute", want.minute, got.minute);
            check_field("out_second", want.second, got.second);
            check_field("epoch_seconds", want.epoch, got.epoch);
            check_field("uptime_ticks", want.uptime, got.uptime);
            check_field("calendar_valid", want.cal_valid, got.cal_valid);
            check_field("applied", want.applied, got.applied);
            check_field("time_checked", want.checked, got.checked);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           kind;
    logic [6:0]           year;
    logic [3:0]           month;
    logic [4:0]           day;
    logic [4:0]           hour;
    logic [5:0]           minute;
    logic [5:0]           second;
    logic                 force_req;
    logic                 out_valid;
    logic                 out_stall;
    logic [6:0]           out_year;
    logic [3:0]           out_month;
    logic [4:0]           out_day;
    logic [4:0]           out_hour;
    logic [5:0]           out_minute;
    logic [5:0]           out_second;
    logic [31:0]          epoch_seconds;
    logic [31:0]          uptime_ticks;
    logic                 calendar_valid;
    logic                 applied;
    logic                 time_checked;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    timekeeper_scoreboard sb = new();

    int          cycle_count = 0;
    int          holdoff_requests = 0;
    int          holdoff_served = 0;
    int          holdoff_left = 0;
    int          stall_left = 0;
    int          calm_left = 0;
    int          sender_calm_left = 0;
    readout_t    seen;
    int unsigned drift_plan[PHASES] = '{0, 65535, 10, 0, 100, 5, 65535, 1};
    int unsigned tps_plan[PHASES] = '{0, 1, 3, 65535, 2, 7, 1000, 1};

    epoch_seconds_timekeeper_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .year           (year),
        .month          (month),
        .day            (day),
        .hour           (hour),
        .minute         (minute),
        .second         (second),
        .force_req      (force_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_year       (out_year),
        .out_month      (out_month),
        .out_day        (out_day),
        .out_hour       (out_hour),
        .out_minute     (out_minute),
        .out_second     (out_second),
        .epoch_seconds  (epoch_seconds),
        .uptime_ticks   (uptime_ticks),
        .calendar_valid (calendar_valid),
        .applied        (applied),
        .time_checked   (time_checked),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Count down a long receiver hold-off, armed by the stimulus
    always @(negedge clk)
    begin
        if (holdoff_served != holdoff_requests)
        begin
            holdoff_served = holdoff_requests;
            holdoff_left = HOLDOFF_CYCLES;
        end
        else if (holdoff_left != 0)
            holdoff_left--;
    end

    // Receiver: check each accepted result, then pick the next stall value
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                seen.year = out_year;
                seen.month = out_month;
                seen.day = out_day;
                seen.hour = out_hour;
                seen.minute = out_minute;
                seen.second = out_second;
                seen.epoch = epoch_seconds;
                seen.uptime = uptime_ticks;
                seen.cal_valid = calendar_valid;
                seen.applied = applied;
                seen.checked = time_checked;
                sb.check_readout(seen);
            end
            if (holdoff_left != 0)
                out_stall <= 1'b1;
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (calm_left != 0)
            begin
                calm_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:66]:
                    begin
                        out_stall <= 1'b0;
                    end
                    [67:92]:
                    begin
                        stall_left = $urandom_range(0, 2);
                        out_stall <= 1'b1;
                    end
                    [93:97]:
                    begin
                        stall_left = $urandom_range(20, 80);
                        out_stall <= 1'b1;
                    end
                    default:
                    begin
                        calm_left = $urandom_range(50, 200);
                        out_stall <= 1'b0;
                    end
                endcase
            end
        end
    end

    function automatic clock_req_t make_req(logic [1:0] k, int y, int mo, int d, int h,
                                            int mi, int s, bit f);
        clock_req_t q;
        q.kind = k;
        q.year = 7'(y);
        q.month = 4'(mo);
        q.day = 5'(d);
        q.hour = 5'(h);
        q.minute = 6'(mi);
        q.second = 6'(s);
        q.force_req = f;
        return q;
    endfunction

    // Random request: ticks, gets, sets near or far from the counter, and unused kinds
    function automatic clock_req_t random_request();
        clock_req_t q;
        readout_t now;
        int pick;
        q = make_req(est_pkg::KIND_TICK, $urandom_range(0, 127), $urandom_range(0, 15),
                     $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63),
                     $urandom_range(0, 63), $urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            q.kind = est_pkg::KIND_TICK;
        else if (pick < 68)
            q.kind = est_pkg::KIND_GET;
        else if (pick < 95)
        begin
            q.kind = est_pkg::KIND_SET;
            now = sb.calendar_of_seconds(sb.secs);
            pick = $urandom_range(0, 99);
            if (pick < 35 && now.cal_valid)
            begin
                // land on the running counter's date, hour and minute, with a random second
                q = make_req(est_pkg::KIND_SET, now.year, now.month, now.day, now.hour,
                             now.minute, now.second, $urandom_range(0, 9) == 0);
                if ($urandom_range(0, 1))
                    q.second = 6'(now.second + $urandom_range(0, 63 - now.second));
                else
                    q.second = 6'($urandom_range(0, now.second));
            end
            else if (pick < 85)
                q = make_req(est_pkg::KIND_SET, $urandom_range(10, 70), $urandom_range(1, 12),
                             $urandom_range(1, 31), $urandom_range(0, 23),
                             $urandom_range(0, 59), $urandom_range(0, 59),
                             $urandom_range(0, 3) == 0);
        end
        else
            q.kind = KIND_UNUSED;
        return q;
    endfunction

    function automatic int idle_cycles();
        int pick;
        if (sender_calm_left != 0)
        begin
            sender_calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 58)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(10, 60);
        sender_calm_left = $urandom_range(20, 60);
        return 0;
    endfunction

    // Offer one request and hold it until accepted; optionally idle after
    task automatic send(clock_req_t q, bit spaced = 1'b1);
        int gap;
        kind <= q.kind;
        year <= q.year;
        month <= q.month;
        day <= q.day;
        hour <= q.hour;
        minute <= q.minute;
        second <= q.second;
        force_req <= q.force_req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(q);
        gap = spaced ? idle_cycles() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every expected result
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_readouts.size() != 0);
    endtask

    // Drain, then let trailing ticks retire before touching registers
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(int idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data <= value[15:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_register(idx, value[15:0]);
    endtask

    task automatic run_random(int count);
        clock_req_t q;
        int taken;
        taken = 0;
        while (taken < count)
        begin
            q = random_request();
            send(q);
            if (q.kind != KIND_UNUSED)
                taken++;
        end
    endtask

    // Block the receiver for a long stretch while sets and gets keep coming
    task automatic holdoff_burst();
        clock_req_t q;
        int n;
        holdoff_requests++;
        for (n = 0; n < 12; n++)
        begin
            q = random_request();
            if (q.kind != est_pkg::KIND_SET)
                q.kind = est_pkg::KIND_GET;
            send(q, 1'b0);
        end
    endtask

    // Main stimulus
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= est_pkg::KIND_TICK;
        year <= '0;
        month <= '0;
        day <= '0;
        hour <= '0;
        minute <= '0;
        second <= '0;
        force_req <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Read right after reset, a few ticks, an unused kind
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));
        repeat (3) send(make_req(est_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
        send(make_req(KIND_UNUSED, 127, 15, 31, 31, 63, 63, 1));

        // Epoch start matches the counter; day zero of the first year wraps
        send(make_req(est_pkg::KIND_SET, 10, 1, 1, 0, 0, 0, 0));
        send(make_req(est_pkg::KIND_SET, 10, 1, 0, 0, 0, 0, 0));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));

        // Last second of the last supported set year, then years outside the set range
        send(make_req(est_pkg::KIND_SET, 70, 12, 31, 23, 59, 59, 1));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));
        send(make_req(est_pkg::KIND_SET, 9, 6, 15, 12, 0, 0, 1));
        send(make_req(est_pkg::KIND_SET, 71, 1, 1, 0, 0, 0, 0));
        send(make_req(est_pkg::KIND_SET, 127, 15, 31, 31, 63, 63, 0));

        // Months past twelve, month zero, oversized time fields
        send(make_req(est_pkg::KIND_SET, 16, 15, 31, 31, 63, 63, 1));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));
        send(make_req(est_pkg::KIND_SET, 12, 0, 1, 0, 0, 0, 1));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));

        // Leap day and the day after it
        send(make_req(est_pkg::KIND_SET, 16, 2, 29, 12, 0, 0, 1));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));
        send(make_req(est_pkg::KIND_SET, 16, 3, 1, 12, 0, 0, 0));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));

        // Drift inside and just past the reset threshold
        send(make_req(est_pkg::KIND_SET, 20, 6, 15, 12, 30, 45, 1));
        send(make_req(est_pkg::KIND_SET, 20, 6, 15, 12, 30, 50, 0));
        send(make_req(est_pkg::KIND_SET, 20, 6, 15, 12, 31, 1, 0));

        // Lower window edge: exactly on it reads invalid, one past reads valid
        send(make_req(est_pkg::KIND_SET, 15, 12, 31, 0, 0, 0, 1));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));
        send(make_req(est_pkg::KIND_SET, 15, 12, 31, 0, 0, 1, 1));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));

        // Lower the tick period below the running sub-second count
        repeat (5) send(make_req(est_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
        settle();
        write_register(est_pkg::REG_TPS, 2);
        send(make_req(est_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));

        // Seconds counter wraps with a zero tick period
        send(make_req(est_pkg::KIND_SET, 10, 1, 0, 23, 59, 59, 1));
        settle();
        write_register(est_pkg::REG_TPS, 0);
        repeat (2) send(make_req(est_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
        send(make_req(est_pkg::KIND_GET, 0, 0, 0, 0, 0, 0, 0));

        // Random phases across register settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            write_register(est_pkg::REG_DRIFT, drift_plan[phase]);
            write_register(est_pkg::REG_TPS, tps_plan[phase]);
            if (phase == 1 || phase == 5)
                holdoff_burst();
            run_random(PHASE_ITEMS / 2);
            if (phase == 3)
                drain();
            run_random(PHASE_ITEMS / 2);
        end

        settle();
        if (sb.mismatches == 0 && sb.pending_readouts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
